>>> rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a condition that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m failed");
// an antecedent that implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`endif

>>> rtl/core/ggrs_pkg.sv
// ----------------------------------------------------------------------------
// ggrs_pkg
// shared types and direction codes of the grid route stepper
// ----------------------------------------------------------------------------
package ggrs_pkg;
   localparam logic [5:0] DirNone      = 6'd0;
   localparam logic [5:0] DirUpLeft    = 6'd49;
   localparam logic [5:0] DirUp        = 6'd50;
   localparam logic [5:0] DirUpRight   = 6'd51;
   localparam logic [5:0] DirLeft      = 6'd52;
   localparam logic [5:0] DirRight     = 6'd54;
   localparam logic [5:0] DirDownLeft  = 6'd55;
   localparam logic [5:0] DirDown      = 6'd56;
   localparam logic [5:0] DirDownRight = 6'd57;

   localparam logic [1:0] CsrMapWidth  = 2'd0;
   localparam logic [1:0] CsrMapHeight = 2'd1;
   localparam logic [1:0] CsrTolerance = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture route request
      logic write_cell; // write one map cell
      logic rd_issue;   // issue neighbor read number rd_idx
      logic [3:0] rd_idx;
      logic rd_capture; // capture returned data for cap_idx
      logic [3:0] cap_idx;
      logic take_step;  // apply chosen move and emit it
      logic finish;     // emit terminator
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic stop;       // walk must end before the next step
      logic [5:0] code; // chosen move, none means stop
   } stat_type;
endpackage

>>> rtl/core/greedy_grid_route_stepper_top.sv
// ----------------------------------------------------------------------------
// greedy_grid_route_stepper_top
// greedy route walker over a signed height map
// ----------------------------------------------------------------------------
// A cell-write transaction is cmd 0. A route transaction (cmd 1) takes
// up to MAX_STEPS steps (23 by default) and ends after a final check, or
// after one more round of reads when the walk ends blocked. Each step
// reads the center and its eight neighbors through the single read port
// of the map memory, one per cycle, then decides. Each step result and
// the closing terminator are strobed on rsp_valid for one cycle; the
// receiver cannot stall, so results must be taken when shown. busy falls
// in the cycle the terminator is strobed.
module greedy_grid_route_stepper_top import ggrs_pkg::*; #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS = 256,
   parameter int MAX_STEPS = 23
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_cmd,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic signed [7:0] req_cell_value,
   input  logic [7:0] req_target_x,
   input  logic [7:0] req_target_y,
   input  logic [7:0] req_step_limit,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data,
   output logic rsp_valid,
   output logic [5:0] rsp_direction,
   output logic [7:0] rsp_end_x,
   output logic [7:0] rsp_end_y,
   output logic rsp_moved,
   output logic rsp_last
);
`include "assert_macros.svh"
   ctrl_type ctrl;
   stat_type stat;
   logic [8:0] width_ff, height_ff;
   logic [7:0] tol_ff;

   // config registers always accept
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         tol_ff <= 8'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CsrMapWidth:  width_ff <= csr_data;
            CsrMapHeight: height_ff <= csr_data;
            CsrTolerance: tol_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   ggrs_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock, .reset, .req_start(start), .req_cmd, .req_step_limit,
      .stat, .busy, .ctrl
   );

   ggrs_dp #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_dp (
      .clock, .reset, .ctrl, .req_pos_x, .req_pos_y, .req_cell_value,
      .req_target_x, .req_target_y, .cfg_width(width_ff), .cfg_height(height_ff),
      .cfg_tol(tol_ff), .stat, .rsp_valid, .rsp_direction, .rsp_end_x,
      .rsp_end_y, .rsp_moved, .rsp_last
   );

   // a step or a terminator always leads to a result on rsp_valid
   `ASSERT_NEXT(a_rsp_busy, clock, reset, ctrl.take_step || ctrl.finish, rsp_valid)
   // a step and a terminator never coincide
   `ASSERT_ALWAYS(a_one_cmd, clock, reset, !(ctrl.take_step && ctrl.finish))
   // step results carry a real move code
   `ASSERT_ALWAYS(a_code, clock, reset, !rsp_valid || rsp_last || rsp_direction != DirNone)
endmodule

>>> rtl/core/ggrs_ctrl.sv
// ----------------------------------------------------------------------------
// ggrs_ctrl
// sequencer: nine reads per step, decide, emit
// ----------------------------------------------------------------------------
module ggrs_ctrl import ggrs_pkg::*; #(
   parameter int MAX_STEPS = 23
) (
   input  logic clock,
   input  logic reset,
   input  logic req_start,
   input  logic req_cmd,
   input  logic [7:0] req_step_limit,
   input  stat_type stat,
   output logic busy,
   output ctrl_type ctrl
);
   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam logic [SW-1:0] MaxLim = SW'(MAX_STEPS);

   typedef enum logic [2:0] {IDLE, WRITE, CHECK, READ, DECIDE, DONE} state_type;
   state_type state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [SW-1:0] left_ff, left_in;
   logic acc;

   assign acc = req_start && !busy;
   assign busy = (state_ff != IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      left_in = left_ff;
      ctrl = '0;
      ctrl.rd_idx = idx_ff;
      ctrl.cap_idx = idx_ff - 4'd1;
      case (state_ff)
         IDLE: begin
            if (acc) begin
               if (req_cmd) begin
                  ctrl.load = 1'b1;
                  state_in = CHECK;
                  left_in = (req_step_limit > 8'(MAX_STEPS)) ? MaxLim
                            : SW'(req_step_limit);
               end else begin
                  state_in = WRITE;
               end
            end
         end
         WRITE: begin
            ctrl.write_cell = 1'b1;
            state_in = IDLE;
         end
         CHECK: begin
            if (left_ff == '0 || stat.stop) begin
               state_in = DONE;
            end else begin
               idx_in = 4'd0;
               state_in = READ;
            end
         end
         READ: begin
            // read data returns in the cycle after issue
            ctrl.rd_issue = (idx_ff < 4'd9);
            ctrl.rd_capture = (idx_ff != 4'd0);
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd9) state_in = DECIDE;
         end
         DECIDE: begin
            if (stat.code == DirNone) begin
               state_in = DONE;
            end else begin
               ctrl.take_step = 1'b1;
               left_in = left_ff - SW'(1);
               state_in = CHECK;
            end
         end
         DONE: begin
            ctrl.finish = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         idx_ff <= '0;
         left_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         left_ff <= left_in;
      end
   end
endmodule

>>> rtl/core/ggrs_dp.sv
// ----------------------------------------------------------------------------
// ggrs_dp
// height map, walk position, passability and move choice
// ----------------------------------------------------------------------------
module ggrs_dp import ggrs_pkg::*; #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic clock,
   input  logic reset,
   input  ctrl_type ctrl,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic signed [7:0] req_cell_value,
   input  logic [7:0] req_target_x,
   input  logic [7:0] req_target_y,
   input  logic [8:0] cfg_width,
   input  logic [8:0] cfg_height,
   input  logic [7:0] cfg_tol,
   output stat_type stat,
   output logic rsp_valid,
   output logic [5:0] rsp_direction,
   output logic [7:0] rsp_end_x,
   output logic [7:0] rsp_end_y,
   output logic rsp_moved,
   output logic rsp_last
);
   localparam int Depth = MAX_COLUMNS * MAX_ROWS;
   localparam int AW = $clog2(Depth);
   localparam int CW = $clog2(MAX_COLUMNS + 1) > 9 ? $clog2(MAX_COLUMNS + 1) : 9;
   localparam int RW = $clog2(MAX_ROWS + 1) > 9 ? $clog2(MAX_ROWS + 1) : 9;

   logic signed [7:0] mem [Depth];
   logic signed [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic signed [7:0] nb_ff [9];
   logic [7:0] x_ff, y_ff, sx_ff, sy_ff, tx_ff, ty_ff;
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [8:0] wr_x, wr_y;
   logic signed [9:0] rx, ry;
   logic [AW+9:0] lin;
   logic ax, ay, cx, cy;
   logic [7:0] buf_ff;
   logic [7:0] wr_px_ff, wr_py_ff;
   logic signed [9:0] hi, lo;
   logic [8:0] pass;
   logic pn, pne, pe, pse, ps, psw, pw, pnw;
   logic gxp, gxn, gyp, gyn, gx0, gy0, adj;
   logic [5:0] code;
   logic wr_ok;
   logic [AW+9:0] wr_lin;

   assign w_eff = (CW'(cfg_width) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cfg_width);
   assign h_eff = (RW'(cfg_height) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_height);

   // neighbor order: center, n, ne, e, se, s, sw, w, nw
   always_comb begin
      rx = $signed({2'b00, x_ff});
      ry = $signed({2'b00, y_ff});
      case (ctrl.rd_idx)
         4'd1: begin ry = ry - 10'sd1; end
         4'd2: begin rx = rx + 10'sd1; ry = ry - 10'sd1; end
         4'd3: begin rx = rx + 10'sd1; end
         4'd4: begin rx = rx + 10'sd1; ry = ry + 10'sd1; end
         4'd5: begin ry = ry + 10'sd1; end
         4'd6: begin rx = rx - 10'sd1; ry = ry + 10'sd1; end
         4'd7: begin rx = rx - 10'sd1; end
         4'd8: begin rx = rx - 10'sd1; ry = ry - 10'sd1; end
         default: ;
      endcase
      // reads happen only strictly inside the border, so offsets stay in the map
      lin = (AW+10)'(rx[8:0]) + (AW+10)'(w_eff) * (AW+10)'(ry[8:0]);
      rd_addr = lin[AW-1:0];
      wr_x = {1'b0, wr_px_ff};
      wr_y = {1'b0, wr_py_ff};
      wr_lin = (AW+10)'(wr_x) + (AW+10)'(w_eff) * (AW+10)'(wr_y);
      wr_ok = (CW'(wr_x) < w_eff) && (RW'(wr_y) < h_eff) && (wr_lin < (AW+10)'(Depth));
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_cell && wr_ok) mem[wr_lin[AW-1:0]] <= buf_ff;
      if (ctrl.rd_issue) rd_data_ff <= mem[rd_addr];
   end

   // cell write fields are held from request until the write cycle
   always_ff @(posedge clock) begin
      if (!ctrl.write_cell) begin
         buf_ff <= req_cell_value;
         wr_px_ff <= req_pos_x;
         wr_py_ff <= req_pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_capture) nb_ff[ctrl.cap_idx] <= rd_data_ff;
   end

   always_comb begin
      hi = 10'(nb_ff[0]) + $signed({2'b00, cfg_tol});
      lo = 10'(nb_ff[0]) - $signed({2'b00, cfg_tol});
      for (int i = 0; i < 9; i++) begin
         pass[i] = (10'(nb_ff[i]) < hi) && (10'(nb_ff[i]) > lo);
      end
      pn = pass[1]; pne = pass[2]; pe = pass[3]; pse = pass[4];
      ps = pass[5]; psw = pass[6]; pw = pass[7]; pnw = pass[8];
      gxp = tx_ff > x_ff; gxn = tx_ff < x_ff; gx0 = !gxp && !gxn;
      gyp = ty_ff > y_ff; gyn = ty_ff < y_ff; gy0 = !gyp && !gyn;
      ax = (9'(tx_ff) == 9'(x_ff) + 9'd1) || (9'(tx_ff) + 9'd1 == 9'(x_ff));
      ay = (9'(ty_ff) == 9'(y_ff) + 9'd1) || (9'(ty_ff) + 9'd1 == 9'(y_ff));
      adj = ax || ay;
      code = DirNone;
      if      (gx0 && gyp && ps) code = DirDown;
      else if (gx0 && gyn && pn) code = DirUp;
      else if (gxp && gyn && pne && (pn || pe)) code = DirUpRight;
      else if (gxp && gy0 && pe) code = DirRight;
      else if (gxp && gyp && pse && (ps || pe)) code = DirDownRight;
      else if (gxn && gyp && psw && (ps || pw)) code = DirDownLeft;
      else if (gxn && gy0 && pw) code = DirLeft;
      else if (gxn && gyn && pnw && (pn || pw)) code = DirUpLeft;
      else if (gxp && gyn && pe) code = DirRight;
      else if (gxp && gyn && pn) code = DirUp;
      else if (gxp && gyp && pe) code = DirRight;
      else if (gxp && gyp && ps) code = DirDown;
      else if (gxn && gyp && pw) code = DirLeft;
      else if (gxn && gyp && ps) code = DirDown;
      else if (gxn && gyn && pw) code = DirLeft;
      else if (gxn && gyn && pn) code = DirUp;
      else if (adj) code = DirNone;
      else if (gx0 && gyp && pse && (ps || pe)) code = DirDownRight;
      else if (gx0 && gyp && psw && (ps || pw)) code = DirDownLeft;
      else if (gx0 && gyn && pne && (pn || pe)) code = DirUpRight;
      else if (gx0 && gyn && pnw && (pn || pw)) code = DirUpLeft;
      else if (gxn && gy0 && psw && (ps || pw)) code = DirDownLeft;
      else if (gxn && gy0 && pnw && (pn || pw)) code = DirUpLeft;
      else if (gxp && gy0 && pse && (ps || pe)) code = DirDownRight;
      else if (gxp && gy0 && pne && (pn || pe)) code = DirUpRight;
      stat.code = code;
      cx = (x_ff < 8'd1) || (CW'(x_ff) + CW'(2) > w_eff);
      cy = (y_ff < 8'd1) || (RW'(y_ff) + RW'(2) > h_eff);
      stat.stop = cx || cy || (x_ff == tx_ff && y_ff == ty_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= req_pos_x; y_ff <= req_pos_y;
         sx_ff <= req_pos_x; sy_ff <= req_pos_y;
         tx_ff <= req_target_x; ty_ff <= req_target_y;
      end else if (ctrl.take_step) begin
         if (code == DirUpLeft || code == DirLeft || code == DirDownLeft) x_ff <= x_ff - 8'd1;
         if (code == DirUpRight || code == DirRight || code == DirDownRight) x_ff <= x_ff + 8'd1;
         if (code == DirUpLeft || code == DirUp || code == DirUpRight) y_ff <= y_ff - 8'd1;
         if (code == DirDownLeft || code == DirDown || code == DirDownRight) y_ff <= y_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.take_step || ctrl.finish;
      end
      rsp_direction <= ctrl.finish ? DirNone : code;
      rsp_end_x <= ctrl.finish ? x_ff : 8'd0;
      rsp_end_y <= ctrl.finish ? y_ff : 8'd0;
      rsp_moved <= ctrl.finish && (x_ff != sx_ff || y_ff != sy_ff);
      rsp_last <= ctrl.finish;
   end
endmodule
